// ===== rtl/rrse_pkg.sv =====
package rrse_pkg;

  localparam int MaxColumnsDefault = 8;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_XOR   = 3'd1,
    CMD_SUB   = 3'd2,
    CMD_SHIFT = 3'd3,
    CMD_MIX   = 3'd4,
    CMD_READ  = 3'd5
  } cmd_t;

  typedef enum logic [0:0] {
    REG_COLUMNS = 1'd0,
    REG_INVERSE = 1'd1
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_SHIFT,
    ST_MIX_LOAD,
    ST_MIX_RUN,
    ST_MIX_STORE,
    ST_OUT
  } state_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gf_mul = p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] base;
    r = 8'h01;
    base = a;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gf_mul(r, base);
      base = gf_mul(base, base);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    rotl8 = (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_fwd(input logic [7:0] v);
    logic [7:0] b;
    b = gf_inv(v);
    sbox_fwd = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] v);
    sbox_inv = gf_inv(rotl8(v, 1) ^ rotl8(v, 3) ^ rotl8(v, 6) ^ 8'h05);
  endfunction

endpackage

// ===== rtl/rrse_sbox.sv =====
module rrse_sbox (
  input  logic       inverse,
  input  logic [7:0] din,
  output logic [7:0] dout
);
  import rrse_pkg::*;

  logic [7:0] fwd_table [256];
  logic [7:0] inv_table [256];

  always_comb begin
    for (int i = 0; i < 256; i++) begin
      fwd_table[i] = sbox_fwd(8'(i));
      inv_table[i] = sbox_inv(8'(i));
    end
  end

  assign dout = inverse ? inv_table[din] : fwd_table[din];
endmodule

// ===== rtl/rrse_mixer.sv =====
module rrse_mixer (
  input  logic       inverse,
  input  logic [7:0] a0,
  input  logic [7:0] a1,
  input  logic [7:0] a2,
  input  logic [7:0] a3,
  output logic [7:0] dout
);
  import rrse_pkg::*;

  always_comb begin
    if (inverse) begin
      dout = gf_mul(8'h0e, a0) ^ gf_mul(8'h0b, a1) ^ gf_mul(8'h0d, a2) ^ gf_mul(8'h09, a3);
    end else begin
      dout = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
    end
  end
endmodule

// ===== rtl/rijndael_round_state_engine.sv =====
// Command engine over a Rijndael state of 4 rows by up to MAX_COLUMNS columns held in a
// byte memory with one registered read port and one write port. A word is accepted only
// in the idle state, so one word is in flight at a time. Byte write, key XOR and read
// act on one byte in the output state. SubBytes walks the active bytes through one S-box,
// one byte per cycle. ShiftRows reads each of rows 1 to 3 into a row buffer and writes it
// back rotated, one byte per cycle. MixColumns loads the 4 bytes of a column, passes a run
// state and writes the 4 mixed bytes back, one per cycle. The single read and single
// write port of the memory set this byte-serial pace. Every word yields one result word,
// which is zero except for a read.
module rijndael_round_state_engine #(
  parameter int MAX_COLUMNS = rrse_pkg::MaxColumnsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cmd [2:0], byte_index [7:3], data_byte [15:8]
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_byte [7:0]
  output logic [7:0]  m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);
  import rrse_pkg::*;

  localparam int Bytes = 4 * MAX_COLUMNS;
  localparam int AW = $clog2(Bytes);

  logic [7:0] mem [Bytes];
  logic [3:0] block_columns;
  logic inverse_mode;
  state_t state, state_next;
  logic [2:0] cmd;
  logic [4:0] idx;
  logic [7:0] data;
  logic [5:0] cnt, cnt_next;
  logic [7:0] rbuf [8];
  logic [7:0] col [4];
  logic [7:0] rd;
  logic [7:0] result, result_next;
  logic [5:0] raddr, waddr;
  logic we;
  logic [7:0] wdata;
  logic [3:0] nb;
  logic [5:0] total;
  logic [7:0] sb_out, mix_out;
  logic [1:0] rrow;
  logic [2:0] ccol;
  logic [3:0] shamt;
  logic [3:0] srcc;
  logic pend;

  assign nb = (block_columns < 4'd4) ? 4'd4 :
              (block_columns > 4'(MAX_COLUMNS)) ? 4'(MAX_COLUMNS) : block_columns;
  assign total = {nb, 2'b00};

  rrse_sbox u_sbox (.inverse(inverse_mode), .din(rd), .dout(sb_out));
  rrse_mixer u_mix (.inverse(inverse_mode), .a0(col[cnt[1:0]]), .a1(col[cnt[1:0] + 2'd1]),
                    .a2(col[cnt[1:0] + 2'd2]), .a3(col[cnt[1:0] + 2'd3]), .dout(mix_out));

  always_ff @(posedge clk) begin
    if (rst) begin
      block_columns <= 4'd4;
      inverse_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_t'(cfg_index))
        REG_COLUMNS: block_columns <= cfg_data;
        REG_INVERSE: inverse_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[raddr[AW-1:0]];
    if (we && waddr < 6'(Bytes)) mem[waddr[AW-1:0]] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      pend <= (state == ST_IDLE && s_tvalid) ? 1'b0 : (state != ST_IDLE);
    end
    result <= result_next;
    if (state == ST_IDLE && s_tvalid) begin
      cmd <= s_tdata[2:0];
      idx <= s_tdata[7:3];
      data <= s_tdata[15:8];
    end
    if (state == ST_SHIFT && !cnt[3]) rbuf[ccol] <= rd;
    if (state == ST_MIX_LOAD) col[cnt[1:0]] <= rd;
  end

  // ShiftRows per row: the row is read into rbuf, then written back rotated.
  assign rrow = 2'(cnt[5:4]) + 2'd1;
  assign ccol = cnt[2:0];
  always_comb begin
    if (nb == 4'd8) shamt = (rrow == 2'd1) ? 4'd1 : (rrow == 2'd2) ? 4'd3 : 4'd4;
    else shamt = {2'b00, rrow};
    if (inverse_mode) shamt = nb - shamt;
    srcc = {1'b0, ccol} + shamt;
    if (srcc >= nb) srcc = srcc - nb;
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    result_next = result;
    raddr = {1'b0, idx};
    waddr = {1'b0, idx};
    we = 1'b0;
    wdata = rd;
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_OUT) && pend;
    unique case (state)
      ST_IDLE: begin
        raddr = {1'b0, s_tdata[7:3]};
        cnt_next = '0;
        if (s_tvalid) begin
          unique case (s_tdata[2:0])
            CMD_SUB: begin
              state_next = ST_SUB;
              raddr = '0;
            end
            CMD_SHIFT: begin
              state_next = ST_SHIFT;
              raddr = 6'd1;
            end
            CMD_MIX: begin
              state_next = ST_MIX_LOAD;
              raddr = '0;
            end
            default: state_next = ST_OUT;
          endcase
          result_next = 8'h00;
        end
      end
      ST_SUB: begin
        // rd holds byte cnt; write its substitute, read next
        raddr = cnt + 6'd1;
        waddr = cnt;
        wdata = sb_out;
        we = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt + 6'd1 == total) state_next = ST_OUT;
      end
      ST_SHIFT: begin
        // cnt[5:4] row-1, cnt[3] phase, cnt[2:0] column
        if (!cnt[3]) begin
          raddr = {1'b0, ccol + 3'd1, 2'(rrow)};
          if ({1'b0, ccol} + 4'd1 == nb) cnt_next = {cnt[5:4], 1'b1, 3'd0};
          else cnt_next = cnt + 6'd1;
        end else begin
          waddr = {1'b0, ccol, rrow};
          wdata = rbuf[srcc[2:0]];
          we = 1'b1;
          raddr = {1'b0, 3'd0, rrow + 2'd1};
          if ({1'b0, ccol} + 4'd1 == nb) begin
            cnt_next = {cnt[5:4] + 2'd1, 1'b0, 3'd0};
            if (rrow == 2'd3) state_next = ST_OUT;
          end else cnt_next = cnt + 6'd1;
        end
      end
      ST_MIX_LOAD: begin
        // cnt[5:2] column, cnt[1:0] byte held in rd
        raddr = cnt + 6'd1;
        cnt_next = cnt + 6'd1;
        if (cnt[1:0] == 2'd3) begin
          state_next = ST_MIX_RUN;
          cnt_next = {cnt[5:2], 2'd0};
        end
      end
      ST_MIX_RUN: begin
        state_next = ST_MIX_STORE;
      end
      ST_MIX_STORE: begin
        waddr = cnt;
        wdata = mix_out;
        we = 1'b1;
        raddr = cnt + 6'd1;
        cnt_next = cnt + 6'd1;
        if (cnt[1:0] == 2'd3) begin
          if (cnt + 6'd1 == total) state_next = ST_OUT;
          else state_next = ST_MIX_LOAD;
        end
      end
      ST_OUT: begin
        if (!pend) begin
          unique case (cmd)
            CMD_WRITE: begin
              we = 1'b1;
              wdata = data;
            end
            CMD_XOR: begin
              we = 1'b1;
              wdata = rd ^ data;
            end
            CMD_READ: result_next = ({1'b0, idx} < 6'(Bytes)) ? rd : 8'h00;
            default: ;
          endcase
        end
        if (m_tready && pend) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign m_tdata = result;
endmodule
